[hdl/assert_macros.svh]
// Assertion macros shared by the steering core RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

[hdl/eos_pkg.sv]
// Shared types, register indexes and command constants of the steering core.
// No dependencies.
package eos_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned INDEX_W   = 3;
    localparam int unsigned SPEED_W   = 17;
    localparam int unsigned RATE_W    = 21;
    localparam int unsigned LED_W     = 2;

    localparam logic [INDEX_W-1:0] REG_OBSTACLE_MARGIN      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_SIDE_OBSTACLE_MARGIN = 3'd1;
    localparam logic [INDEX_W-1:0] REG_GROUND_MARGIN        = 3'd2;
    localparam logic [INDEX_W-1:0] REG_OFFSET_SIDE_LEFT     = 3'd3;
    localparam logic [INDEX_W-1:0] REG_OFFSET_CENTER_LEFT   = 3'd4;
    localparam logic [INDEX_W-1:0] REG_OFFSET_CENTER_RIGHT  = 3'd5;
    localparam logic [INDEX_W-1:0] REG_OFFSET_SIDE_RIGHT    = 3'd6;

    localparam logic [LED_W-1:0] LED_GREEN     = 2'd0;
    localparam logic [LED_W-1:0] LED_BLUE      = 2'd1;
    localparam logic [LED_W-1:0] LED_RED       = 2'd2;
    localparam logic [LED_W-1:0] LED_UNCHANGED = 2'd3;

    localparam logic [SPEED_W-1:0]       SPEED_CRUISE = 17'd100000;
    localparam logic [SPEED_W-1:0]       SPEED_ZERO   = 17'd0;
    localparam logic signed [RATE_W-1:0] TURN_RATE    = 21'sd600000;
    localparam logic signed [RATE_W-1:0] RATE_ZERO    = 21'sd0;

    typedef struct packed {
        logic [VALUE_W-1:0] obstacle_margin;
        logic [VALUE_W-1:0] side_obstacle_margin;
        logic [VALUE_W-1:0] ground_margin;
        logic [VALUE_W-1:0] offset_side_left;
        logic [VALUE_W-1:0] offset_center_left;
        logic [VALUE_W-1:0] offset_center_right;
        logic [VALUE_W-1:0] offset_side_right;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0] side_left_raw;
        logic [VALUE_W-1:0] center_left_raw;
        logic [VALUE_W-1:0] center_right_raw;
        logic [VALUE_W-1:0] side_right_raw;
        logic               read_failed;
    } sample_t;

    typedef struct packed {
        logic                      motor_command_sent;
        logic [SPEED_W-1:0]        speed_command;
        logic signed [RATE_W-1:0]  turn_rate_command;
        logic [LED_W-1:0]          led_side_left;
        logic [LED_W-1:0]          led_center_left;
        logic [LED_W-1:0]          led_center_right;
        logic [LED_W-1:0]          led_side_right;
        logic                      halted_flag;
    } result_t;

endpackage

[hdl/eos_cfg_regs.sv]
// Configuration register file of the steering core: margins and sensor offsets.
// Depends on eos_pkg.
module eos_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [eos_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [eos_pkg::VALUE_W-1:0]  cfg_data,
    output eos_pkg::cfg_t                cfg
);

    eos_pkg::cfg_t cfg_reg;
    eos_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                eos_pkg::REG_OBSTACLE_MARGIN:      cfg_next.obstacle_margin      = cfg_data;
                eos_pkg::REG_SIDE_OBSTACLE_MARGIN: cfg_next.side_obstacle_margin = cfg_data;
                eos_pkg::REG_GROUND_MARGIN:        cfg_next.ground_margin        = cfg_data;
                eos_pkg::REG_OFFSET_SIDE_LEFT:     cfg_next.offset_side_left     = cfg_data;
                eos_pkg::REG_OFFSET_CENTER_LEFT:   cfg_next.offset_center_left   = cfg_data;
                eos_pkg::REG_OFFSET_CENTER_RIGHT:  cfg_next.offset_center_right  = cfg_data;
                eos_pkg::REG_OFFSET_SIDE_RIGHT:    cfg_next.offset_side_right    = cfg_data;
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.obstacle_margin      <= 16'd100;
            cfg_reg.side_obstacle_margin <= 16'd7500;
            cfg_reg.ground_margin        <= 16'd30;
            cfg_reg.offset_side_left     <= 16'd2486;
            cfg_reg.offset_center_left   <= 16'd2502;
            cfg_reg.offset_center_right  <= 16'd2472;
            cfg_reg.offset_side_right    <= 16'd2442;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/eos_steer.sv]
// Sensor evaluation, LED classification and turn state of the steering core.
// Depends on eos_pkg; the turn state advances once per transaction on fire.
module eos_steer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  eos_pkg::cfg_t    cfg,
    input  eos_pkg::sample_t sample,
    output eos_pkg::result_t result
);

    typedef enum logic [1:0]
    {
        MODE_STRAIGHT,
        MODE_LEFT,
        MODE_RIGHT
    } mode_t;

    typedef logic [eos_pkg::VALUE_W-1:0] value_t;

    mode_t mode_reg;
    mode_t mode_next;
    logic  stopped_reg;
    logic  stopped_next;

    value_t osl, ocl, ocr, osr;
    value_t gsl, gcl, gcr, gsr;
    value_t side;
    logic   edge_seen;
    logic   obstacle_seen;

    function automatic value_t above(input value_t raw, input value_t off);
        logic [eos_pkg::VALUE_W:0] diff;
        diff = {1'b0, raw} - {1'b0, off};
        return diff[eos_pkg::VALUE_W] ? '0 : diff[eos_pkg::VALUE_W-1:0];
    endfunction

    function automatic logic [eos_pkg::LED_W-1:0] color(input value_t ob, input value_t gr,
                                                        input value_t om, input value_t gm);
        logic [eos_pkg::LED_W-1:0] c;
        if (gr > gm)
            c = eos_pkg::LED_RED;
        else if (ob > om)
            c = eos_pkg::LED_BLUE;
        else
            c = eos_pkg::LED_GREEN;
        return c;
    endfunction

    always_comb
    begin
        osl = above(sample.side_left_raw, cfg.offset_side_left);
        ocl = above(sample.center_left_raw, cfg.offset_center_left);
        ocr = above(sample.center_right_raw, cfg.offset_center_right);
        osr = above(sample.side_right_raw, cfg.offset_side_right);
        gsl = above(cfg.offset_side_left, sample.side_left_raw);
        gcl = above(cfg.offset_center_left, sample.center_left_raw);
        gcr = above(cfg.offset_center_right, sample.center_right_raw);
        gsr = above(cfg.offset_side_right, sample.side_right_raw);
        side = (osl > osr) ? osl : osr;
        edge_seen = (gcl > cfg.ground_margin) || (gcr > cfg.ground_margin);
        obstacle_seen = (ocl > cfg.obstacle_margin) || (ocr > cfg.obstacle_margin)
                        || (side > cfg.side_obstacle_margin);
    end

    always_comb
    begin
        mode_next    = mode_reg;
        stopped_next = stopped_reg;

        result.motor_command_sent = 1'b0;
        result.speed_command      = eos_pkg::SPEED_ZERO;
        result.turn_rate_command  = eos_pkg::RATE_ZERO;
        result.led_side_left      = color(osl, gsl, cfg.obstacle_margin, cfg.ground_margin);
        result.led_center_left    = color(ocl, gcl, cfg.obstacle_margin, cfg.ground_margin);
        result.led_center_right   = color(ocr, gcr, cfg.obstacle_margin, cfg.ground_margin);
        result.led_side_right     = color(osr, gsr, cfg.obstacle_margin, cfg.ground_margin);
        result.halted_flag        = 1'b0;

        if (stopped_reg || sample.read_failed)
        begin
            result.motor_command_sent = !stopped_reg;
            result.led_side_left      = eos_pkg::LED_UNCHANGED;
            result.led_center_left    = eos_pkg::LED_UNCHANGED;
            result.led_center_right   = eos_pkg::LED_UNCHANGED;
            result.led_side_right     = eos_pkg::LED_UNCHANGED;
            result.halted_flag        = 1'b1;
            stopped_next              = 1'b1;
        end
        else if (edge_seen || obstacle_seen)
        begin
            if (mode_reg == MODE_STRAIGHT)
            begin
                result.motor_command_sent = 1'b1;
                if (edge_seen ? (gcl < gcr) : ((ocl < ocr) && (gcl == '0)))
                begin
                    mode_next                = MODE_LEFT;
                    result.turn_rate_command = eos_pkg::TURN_RATE;
                end
                else
                begin
                    mode_next                = MODE_RIGHT;
                    result.turn_rate_command = -eos_pkg::TURN_RATE;
                end
            end
        end
        else
        begin
            mode_next                 = MODE_STRAIGHT;
            result.motor_command_sent = 1'b1;
            result.speed_command      = eos_pkg::SPEED_CRUISE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_STRAIGHT;
            stopped_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

[hdl/edge_obstacle_steering_core.sv]
// Edge and obstacle steering core: sample register, steering logic, result register.
// Depends on eos_pkg, eos_cfg_regs, eos_steer and assert_macros.svh.
//
// Use: present one front sensor reading on the sample channel (sample_valid high,
// four raw readings and read_failed); it is taken at a clock edge with sample_stall
// low. Each transaction yields exactly one result on the result channel, taken at
// an edge where result_valid is high and result_stall is low.
// Datapath: a taken sample moves through the sample register and then the result register.
// Throughput: one transaction per cycle while results are not stalled, set by the single
// compare stage between the sample register and the result register; the turn state
// updates as a sample moves into the result register, so the next sample sees it at once.
// Stall: while result_stall holds a waiting result, one more sample is held in the
// sample register; after that sample_stall rises until the result is taken.
// Reset: clears both registers' valid flags, the turn state to straight, the halt
// flag, and the configuration registers to their reset margins and offsets.
// Configuration: write cfg_data to register cfg_index with cfg_we, only while idle.
// After a read failure every later result reports halted with no command.
`include "assert_macros.svh"

module edge_obstacle_steering_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [eos_pkg::INDEX_W-1:0]           cfg_index,
    input  logic [eos_pkg::VALUE_W-1:0]           cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic [eos_pkg::VALUE_W-1:0]           side_left_raw,
    input  logic [eos_pkg::VALUE_W-1:0]           center_left_raw,
    input  logic [eos_pkg::VALUE_W-1:0]           center_right_raw,
    input  logic [eos_pkg::VALUE_W-1:0]           side_right_raw,
    input  logic                                  read_failed,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic                                  motor_command_sent,
    output logic [eos_pkg::SPEED_W-1:0]           speed_command,
    output logic signed [eos_pkg::RATE_W-1:0]     turn_rate_command,
    output logic [eos_pkg::LED_W-1:0]             led_side_left,
    output logic [eos_pkg::LED_W-1:0]             led_center_left,
    output logic [eos_pkg::LED_W-1:0]             led_center_right,
    output logic [eos_pkg::LED_W-1:0]             led_side_right,
    output logic                                  halted_flag
);

    eos_pkg::cfg_t    cfg;
    eos_pkg::sample_t sample_reg;
    eos_pkg::result_t result_reg;
    eos_pkg::result_t result_next;
    logic             sample_valid_reg;
    logic             sample_valid_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             advance;
    logic             take;
    logic             fire;

    eos_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    eos_steer u_steer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cfg    (cfg),
        .sample (sample_reg),
        .result (result_next)
    );

    assign advance      = !result_valid_reg || !result_stall;
    assign sample_stall = sample_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;
    assign fire         = sample_valid_reg && advance;

    always_comb
    begin
        sample_valid_next = sample_valid_reg;
        if (take)
            sample_valid_next = 1'b1;
        else if (advance)
            sample_valid_next = 1'b0;
        result_valid_next = advance ? sample_valid_reg : result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sample_valid_reg <= sample_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg.side_left_raw    <= side_left_raw;
            sample_reg.center_left_raw  <= center_left_raw;
            sample_reg.center_right_raw <= center_right_raw;
            sample_reg.side_right_raw   <= side_right_raw;
            sample_reg.read_failed      <= read_failed;
        end
        if (fire)
            result_reg <= result_next;
    end

    assign result_valid       = result_valid_reg;
    assign motor_command_sent = result_reg.motor_command_sent;
    assign speed_command      = result_reg.speed_command;
    assign turn_rate_command  = result_reg.turn_rate_command;
    assign led_side_left      = result_reg.led_side_left;
    assign led_center_left    = result_reg.led_center_left;
    assign led_center_right   = result_reg.led_center_right;
    assign led_side_right     = result_reg.led_side_right;
    assign halted_flag        = result_reg.halted_flag;

    `ASSERT_IMPLY(a_idle_cmd_zero, clk, rst_n, result_valid && !motor_command_sent, (speed_command == '0) && (turn_rate_command == '0), "no command but nonzero speed or rate")
    `ASSERT_IMPLY(a_halt_zero, clk, rst_n, result_valid && halted_flag, (speed_command == '0) && (turn_rate_command == '0) && (led_side_left == eos_pkg::LED_UNCHANGED), "halted result carries a command")
    `ASSERT_IMPLY(a_cruise_straight, clk, rst_n, result_valid && (speed_command != '0), turn_rate_command == '0, "cruise with turn rate")
    `ASSERT_NEXT(a_halt_sticky, clk, rst_n, result_valid && !result_stall && halted_flag, !result_valid || halted_flag, "halt not kept")

endmodule

[sim/steering_checker.sv]
// Checker for edge_obstacle_steering_core: watches the register port and both channels,
// predicts each steering result and compares it field by field as results are taken.
// Depends on eos_pkg.
module steering_checker
    import eos_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [INDEX_W-1:0]        cfg_index,
    input  logic [VALUE_W-1:0]        cfg_data,
    input  logic                      sample_valid,
    input  logic                      sample_stall,
    input  logic [VALUE_W-1:0]        side_left_raw,
    input  logic [VALUE_W-1:0]        center_left_raw,
    input  logic [VALUE_W-1:0]        center_right_raw,
    input  logic [VALUE_W-1:0]        side_right_raw,
    input  logic                      read_failed,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  logic                      motor_command_sent,
    input  logic [SPEED_W-1:0]        speed_command,
    input  logic signed [RATE_W-1:0]  turn_rate_command,
    input  logic [LED_W-1:0]          led_side_left,
    input  logic [LED_W-1:0]          led_center_left,
    input  logic [LED_W-1:0]          led_center_right,
    input  logic [LED_W-1:0]          led_side_right,
    input  logic                      halted_flag,
    output int                        pending_results,
    output int                        mismatch_count
);

    typedef enum logic [1:0]
    {
        STEER_STRAIGHT = 2'd0,
        STEER_LEFT     = 2'd1,
        STEER_RIGHT    = 2'd2
    } steer_t;

    localparam cfg_t CFG_AT_RESET =
        {16'd100, 16'd7500, 16'd30, 16'd2486, 16'd2502, 16'd2472, 16'd2442};

    cfg_t    steer_cfg;
    steer_t  steer_mode;
    logic    halted;
    result_t expected_commands[$];

    initial
    begin
        pending_results = 0;
        mismatch_count  = 0;
    end

    function automatic logic [VALUE_W-1:0] above_offset(input logic [VALUE_W-1:0] raw,
                                                        input logic [VALUE_W-1:0] off);
        return (raw > off) ? raw - off : '0;
    endfunction

    function automatic logic [VALUE_W-1:0] below_offset(input logic [VALUE_W-1:0] raw,
                                                        input logic [VALUE_W-1:0] off);
        return (raw < off) ? off - raw : '0;
    endfunction

    function automatic logic [LED_W-1:0] led_color(input logic [VALUE_W-1:0] obstacle,
                                                   input logic [VALUE_W-1:0] ground);
        if (ground > steer_cfg.ground_margin)
            return LED_RED;
        else if (obstacle > steer_cfg.obstacle_margin)
            return LED_BLUE;
        else
            return LED_GREEN;
    endfunction

    function automatic result_t predict_steering(input sample_t reading);
        result_t cmd;
        logic [VALUE_W-1:0] osl, ocl, ocr, osr, gsl, gcl, gcr, gsr, side;
        cmd = '0;
        cmd.speed_command     = SPEED_ZERO;
        cmd.turn_rate_command = RATE_ZERO;
        if (halted || reading.read_failed)
        begin
            cmd.motor_command_sent = !halted;
            cmd.led_side_left      = LED_UNCHANGED;
            cmd.led_center_left    = LED_UNCHANGED;
            cmd.led_center_right   = LED_UNCHANGED;
            cmd.led_side_right     = LED_UNCHANGED;
            cmd.halted_flag        = 1'b1;
            halted = 1'b1;
        end
        else
        begin
            osl = above_offset(reading.side_left_raw, steer_cfg.offset_side_left);
            ocl = above_offset(reading.center_left_raw, steer_cfg.offset_center_left);
            ocr = above_offset(reading.center_right_raw, steer_cfg.offset_center_right);
            osr = above_offset(reading.side_right_raw, steer_cfg.offset_side_right);
            gsl = below_offset(reading.side_left_raw, steer_cfg.offset_side_left);
            gcl = below_offset(reading.center_left_raw, steer_cfg.offset_center_left);
            gcr = below_offset(reading.center_right_raw, steer_cfg.offset_center_right);
            gsr = below_offset(reading.side_right_raw, steer_cfg.offset_side_right);
            side = (osl > osr) ? osl : osr;
            if (gcl > steer_cfg.ground_margin || gcr > steer_cfg.ground_margin)
            begin
                if (steer_mode == STEER_STRAIGHT)
                begin
                    cmd.motor_command_sent = 1'b1;
                    if (gcl < gcr)
                    begin
                        steer_mode = STEER_LEFT;
                        cmd.turn_rate_command = TURN_RATE;
                    end
                    else
                    begin
                        steer_mode = STEER_RIGHT;
                        cmd.turn_rate_command = -TURN_RATE;
                    end
                end
            end
            else if (ocl > steer_cfg.obstacle_margin || ocr > steer_cfg.obstacle_margin ||
                     side > steer_cfg.side_obstacle_margin)
            begin
                if (steer_mode == STEER_STRAIGHT)
                begin
                    cmd.motor_command_sent = 1'b1;
                    if (ocl < ocr && gcl == '0)
                    begin
                        steer_mode = STEER_LEFT;
                        cmd.turn_rate_command = TURN_RATE;
                    end
                    else
                    begin
                        steer_mode = STEER_RIGHT;
                        cmd.turn_rate_command = -TURN_RATE;
                    end
                end
            end
            else
            begin
                steer_mode = STEER_STRAIGHT;
                cmd.motor_command_sent = 1'b1;
                cmd.speed_command      = SPEED_CRUISE;
            end
            cmd.led_side_left    = led_color(osl, gsl);
            cmd.led_center_left  = led_color(ocl, gcl);
            cmd.led_center_right = led_color(ocr, gcr);
            cmd.led_side_right   = led_color(osr, gsr);
            cmd.halted_flag      = 1'b0;
        end
        return cmd;
    endfunction

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        sample_t reading;
        if (!rst_n)
        begin
            steer_cfg  = CFG_AT_RESET;
            steer_mode = STEER_STRAIGHT;
            halted     = 1'b0;
            expected_commands.delete();
            pending_results <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_commands.size() == 0)
                begin
                    $display("%0t result with no transaction outstanding", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_commands.pop_front();
                    check_field("motor_command_sent", want.motor_command_sent,
                                motor_command_sent);
                    check_field("speed_command", want.speed_command, speed_command);
                    check_field("turn_rate_command", want.turn_rate_command,
                                turn_rate_command);
                    check_field("led_side_left", want.led_side_left, led_side_left);
                    check_field("led_center_left", want.led_center_left, led_center_left);
                    check_field("led_center_right", want.led_center_right, led_center_right);
                    check_field("led_side_right", want.led_side_right, led_side_right);
                    check_field("halted_flag", want.halted_flag, halted_flag);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OBSTACLE_MARGIN:      steer_cfg.obstacle_margin      = cfg_data;
                    REG_SIDE_OBSTACLE_MARGIN: steer_cfg.side_obstacle_margin = cfg_data;
                    REG_GROUND_MARGIN:        steer_cfg.ground_margin        = cfg_data;
                    REG_OFFSET_SIDE_LEFT:     steer_cfg.offset_side_left     = cfg_data;
                    REG_OFFSET_CENTER_LEFT:   steer_cfg.offset_center_left   = cfg_data;
                    REG_OFFSET_CENTER_RIGHT:  steer_cfg.offset_center_right  = cfg_data;
                    REG_OFFSET_SIDE_RIGHT:    steer_cfg.offset_side_right    = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                reading = {side_left_raw, center_left_raw, center_right_raw, side_right_raw,
                           read_failed};
                expected_commands.insert(expected_commands.size(), predict_steering(reading));
            end
            pending_results <= expected_commands.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Top of the steering core testbench: clock, reset, register setup, sensor stimulus,
// random stalls on the result side and the verdict.
// Depends on eos_pkg, edge_obstacle_steering_core and steering_checker.
module tb_top;
    import eos_pkg::*;

    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int PHASES          = 8;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 120;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [INDEX_W-1:0]       cfg_index;
    logic [VALUE_W-1:0]       cfg_data;
    logic                     sample_valid;
    logic                     sample_stall;
    logic [VALUE_W-1:0]       side_left_raw;
    logic [VALUE_W-1:0]       center_left_raw;
    logic [VALUE_W-1:0]       center_right_raw;
    logic [VALUE_W-1:0]       side_right_raw;
    logic                     read_failed;
    logic                     result_valid;
    logic                     result_stall;
    logic                     motor_command_sent;
    logic [SPEED_W-1:0]       speed_command;
    logic signed [RATE_W-1:0] turn_rate_command;
    logic [LED_W-1:0]         led_side_left;
    logic [LED_W-1:0]         led_center_left;
    logic [LED_W-1:0]         led_center_right;
    logic [LED_W-1:0]         led_side_right;
    logic                     halted_flag;
    int                       pending_results;
    int                       mismatch_count;

    cfg_t shaping_cfg = {16'd100, 16'd7500, 16'd30, 16'd2486, 16'd2502, 16'd2472, 16'd2442};
    bit   steady_sender = 1'b0;
    bit   hold_off_req  = 1'b0;

    edge_obstacle_steering_core DUT (.*);

    steering_checker steer_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(3, 1);
        else if (roll < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 20);
    endfunction

    function automatic logic [VALUE_W-1:0] shaped_raw(input logic [VALUE_W-1:0] off,
                                                      input logic [VALUE_W-1:0] margin,
                                                      input logic [VALUE_W-1:0] gm,
                                                      input bit keep_clear);
        int unsigned roll;
        int level;
        roll = keep_clear ? 0 : $urandom_range(99);
        if (roll < 35)
            level = int'(off) + int'($urandom_range(int'(margin) + int'(gm))) - int'(gm);
        else if (roll < 55)
            level = int'(off) - int'(gm) - 1 - int'($urandom_range(200));
        else if (roll < 75)
            level = int'(off) + int'(margin) + 1 + int'($urandom_range(2000));
        else if (roll < 85)
        begin
            case ($urandom_range(3))
                0: level = int'(off) - int'(gm);
                1: level = int'(off) - int'(gm) - 1;
                2: level = int'(off) + int'(margin);
                default: level = int'(off) + int'(margin) + 1;
            endcase
        end
        else if (roll < 95)
            level = int'($urandom_range(65535));
        else
            level = $urandom_range(1) ? 65535 : 0;
        if (level < 0)
            level = 0;
        if (level > 65535)
            level = 65535;
        return level[VALUE_W-1:0];
    endfunction

    function automatic sample_t random_reading();
        sample_t reading;
        bit clear;
        clear = ($urandom_range(99) < 40);
        reading.side_left_raw = shaped_raw(shaping_cfg.offset_side_left,
            (clear || $urandom_range(1)) ? shaping_cfg.obstacle_margin
                                         : shaping_cfg.side_obstacle_margin,
            shaping_cfg.ground_margin, clear);
        reading.center_left_raw = shaped_raw(shaping_cfg.offset_center_left,
            shaping_cfg.obstacle_margin, shaping_cfg.ground_margin, clear);
        reading.center_right_raw = shaped_raw(shaping_cfg.offset_center_right,
            shaping_cfg.obstacle_margin, shaping_cfg.ground_margin, clear);
        reading.side_right_raw = shaped_raw(shaping_cfg.offset_side_right,
            (clear || $urandom_range(1)) ? shaping_cfg.obstacle_margin
                                         : shaping_cfg.side_obstacle_margin,
            shaping_cfg.ground_margin, clear);
        reading.read_failed = 1'b0;
        return reading;
    endfunction

    function automatic cfg_t phase_config(input int phase);
        cfg_t c;
        case (phase)
            1: c = '0;
            2: c = '1;
            3: c = {{3{16'h0000}}, {4{16'hFFFF}}};
            4: c = {{3{16'hFFFF}}, {4{16'h0000}}};
            default:
            begin
                c.obstacle_margin      = $urandom_range(400);
                c.side_obstacle_margin = $urandom_range(12000);
                c.ground_margin        = $urandom_range(200);
                c.offset_side_left     = $urandom_range(60000, 300);
                c.offset_center_left   = $urandom_range(60000, 300);
                c.offset_center_right  = $urandom_range(60000, 300);
                c.offset_side_right    = $urandom_range(60000, 300);
            end
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_config(input cfg_t c);
        write_reg(REG_OBSTACLE_MARGIN, c.obstacle_margin);
        write_reg(REG_SIDE_OBSTACLE_MARGIN, c.side_obstacle_margin);
        write_reg(REG_GROUND_MARGIN, c.ground_margin);
        write_reg(REG_OFFSET_SIDE_LEFT, c.offset_side_left);
        write_reg(REG_OFFSET_CENTER_LEFT, c.offset_center_left);
        write_reg(REG_OFFSET_CENTER_RIGHT, c.offset_center_right);
        write_reg(REG_OFFSET_SIDE_RIGHT, c.offset_side_right);
        write_reg(REG_UNUSED, VALUE_W'($urandom_range(65535)));
        cfg_we <= 1'b0;
        shaping_cfg = c;
    endtask

    task automatic offer(input sample_t reading);
        int unsigned gap;
        gap = steady_sender ? 0 : idle_length();
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        {side_left_raw, center_left_raw, center_right_raw, side_right_raw, read_failed}
            <= reading;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
    endtask

    task automatic offer_reading(input int sl, input int cl, input int cr, input int sr,
                                 input bit fail);
        sample_t reading;
        reading.side_left_raw    = sl[VALUE_W-1:0];
        reading.center_left_raw  = cl[VALUE_W-1:0];
        reading.center_right_raw = cr[VALUE_W-1:0];
        reading.side_right_raw   = sr[VALUE_W-1:0];
        reading.read_failed      = fail;
        offer(reading);
    endtask

    task automatic wait_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int unsigned stall_len;
        int unsigned run_len;
        int unsigned n;
        result_stall <= 1'b0;
        forever
        begin
            if (hold_off_req)
            begin
                stall_len    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                stall_len = idle_length();
            if (stall_len != 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            run_len = ($urandom_range(19) == 0) ? $urandom_range(300, 100)
                                                : $urandom_range(8, 1);
            for (n = 1; n < run_len && !hold_off_req; n++)
                @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t timeout: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        sample_t reading;
        int phase;
        int i;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        sample_valid     <= 1'b0;
        side_left_raw    <= '0;
        center_left_raw  <= '0;
        center_right_raw <= '0;
        side_right_raw   <= '0;
        read_failed      <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset margins and offsets: turn decisions, holds and boundaries
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(0, 0, 0, 0, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 2502, 2372, 2442, 1'b0);
        offer_reading(2486, 2502, 2372, 2442, 1'b0);
        offer_reading(2486, 3002, 2472, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 2502, 2972, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 3002, 2472, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 2492, 2972, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(9987, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 9942, 1'b0);
        offer_reading(65535, 65535, 65535, 65535, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 2472, 2572, 2442, 1'b0);
        offer_reading(2486, 2471, 2572, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2486, 3002, 2372, 2442, 1'b0);
        offer_reading(2486, 2502, 2472, 2442, 1'b0);
        offer_reading(2436, 2452, 2422, 2392, 1'b0);
        wait_until_drained();

        for (phase = 1; phase <= PHASES; phase++)
        begin
            program_config(phase_config(phase));
            if (phase == 5)
                hold_off_req = 1'b1;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                steady_sender = (i % 100) < 30;
                offer(random_reading());
            end
            steady_sender = 1'b0;
            wait_until_drained();
        end

        // read failure, then the halted block
        offer(random_reading());
        reading = random_reading();
        reading.read_failed = 1'b1;
        offer(reading);
        repeat (20)
        begin
            reading = random_reading();
            reading.read_failed = $urandom_range(1);
            offer(reading);
        end
        wait_until_drained();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/eos_pkg.sv
hdl/eos_cfg_regs.sv
hdl/eos_steer.sv
hdl/edge_obstacle_steering_core.sv
sim/steering_checker.sv
sim/tb_top.sv
